/* design/qrm_pkg.sv */
// ----------------------------------------------------------------------------
// qrm_pkg
// Shared widths and pipeline types for the quaternion to rotation matrix block.
// ----------------------------------------------------------------------------
`default_nettype none

package qrm_pkg;

    localparam int FRAC_BITS = 14;
    localparam int IN_W      = 16;
    localparam int OUT_W     = 16;
    localparam int N_LANES   = 9;

    // quotient bits per element: result magnitude is at most 2^(FRAC_BITS+1)
    localparam int Q_W   = FRAC_BITS + 2;
    localparam int PROD_W = 2 * IN_W;
    localparam int NUM_W  = PROD_W + 1;
    localparam int MAG_W  = PROD_W;
    localparam int N_W    = PROD_W + 1;
    localparam int DIV_W  = N_W + 1;
    localparam int REM_W  = DIV_W + 1;
    localparam int DVD_W  = MAG_W + Q_W + 1;
    localparam int VAL_W  = Q_W + 2;

    localparam logic signed [VAL_W-1:0] ONE = VAL_W'(1) <<< FRAC_BITS;

    // diagonal lanes: element = one minus the ratio term
    localparam logic [N_LANES-1:0] DIAG_MASK = 9'b100010001;

    typedef struct packed {
        logic             neg;
        logic [DIV_W-1:0] rem;
        logic [Q_W-1:0]   lo;
        logic [Q_W-1:0]   q;
    } t_lane;

    typedef struct packed {
        logic                      zero;
        logic [DIV_W-1:0]          d;
        t_lane [N_LANES-1:0]       lane;
    } t_div;

    typedef logic signed [N_LANES-1:0][OUT_W-1:0] t_mat;

endpackage

`default_nettype wire

/* design/qrm_prod.sv */
// ----------------------------------------------------------------------------
// qrm_prod
// Front end: ten products, norm and numerators, then divider operands.
// ----------------------------------------------------------------------------
`default_nettype none

module qrm_prod
    import qrm_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_en,
    input  wire logic                   i_valid,
    input  wire logic signed [IN_W-1:0] i_quat_w,
    input  wire logic signed [IN_W-1:0] i_quat_x,
    input  wire logic signed [IN_W-1:0] i_quat_y,
    input  wire logic signed [IN_W-1:0] i_quat_z,
    output logic                        o_valid,
    output t_div                        o_div
);

    logic                     r_va, r_vb, r_vc;
    logic signed [PROD_W-1:0] r_ww, r_xx, r_yy, r_zz, r_xy, r_xz, r_yz, r_wx, r_wy, r_wz;
    logic        [N_W-1:0]    r_n;
    logic signed [NUM_W-1:0]  r_num [N_LANES];
    t_div                     r_div, n_div;

    function automatic logic signed [NUM_W-1:0] sx(input logic signed [PROD_W-1:0] p);
        sx = {p[PROD_W-1], p};
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
        end else if (i_en) begin
            r_va <= i_valid;
            r_vb <= r_va;
            r_vc <= r_vb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ww <= i_quat_w * i_quat_w;
            r_xx <= i_quat_x * i_quat_x;
            r_yy <= i_quat_y * i_quat_y;
            r_zz <= i_quat_z * i_quat_z;
            r_xy <= i_quat_x * i_quat_y;
            r_xz <= i_quat_x * i_quat_z;
            r_yz <= i_quat_y * i_quat_z;
            r_wx <= i_quat_w * i_quat_x;
            r_wy <= i_quat_w * i_quat_y;
            r_wz <= i_quat_w * i_quat_z;

            r_n <= {1'b0, r_ww} + {1'b0, r_xx} + {1'b0, r_yy} + {1'b0, r_zz};
            r_num[0] <= sx(r_yy) + sx(r_zz);
            r_num[1] <= sx(r_xy) - sx(r_wz);
            r_num[2] <= sx(r_xz) + sx(r_wy);
            r_num[3] <= sx(r_xy) + sx(r_wz);
            r_num[4] <= sx(r_xx) + sx(r_zz);
            r_num[5] <= sx(r_yz) - sx(r_wx);
            r_num[6] <= sx(r_xz) - sx(r_wy);
            r_num[7] <= sx(r_yz) + sx(r_wx);
            r_num[8] <= sx(r_xx) + sx(r_yy);

            r_div <= n_div;
        end
    end

    // magnitude and dividend (mag << Q_W) + n; high part seeds the remainder
    always_comb begin
        logic [NUM_W-1:0] mag;
        logic [DVD_W-1:0] dvd;
        n_div.zero = (r_n == '0);
        n_div.d    = {r_n, 1'b0};
        for (int k = 0; k < N_LANES; k++) begin
            mag = r_num[k][NUM_W-1] ? NUM_W'(-r_num[k]) : NUM_W'(r_num[k]);
            dvd = {1'b0, mag[MAG_W-1:0], {Q_W{1'b0}}} + DVD_W'(r_n);
            n_div.lane[k].neg = r_num[k][NUM_W-1];
            n_div.lane[k].rem = DIV_W'(dvd[DVD_W-1:Q_W]);
            n_div.lane[k].lo  = dvd[Q_W-1:0];
            n_div.lane[k].q   = '0;
        end
    end

    assign o_valid = r_vc;
    assign o_div   = r_div;

endmodule

`default_nettype wire

/* design/qrm_div_step.sv */
// ----------------------------------------------------------------------------
// qrm_div_step
// One registered restoring-division step for all nine lanes.
// ----------------------------------------------------------------------------
`default_nettype none

module qrm_div_step
    import qrm_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_en,
    input  wire logic i_valid,
    input  wire t_div i_div,
    output logic      o_valid,
    output t_div      o_div
);

    logic r_valid;
    t_div r_div, n_div;

    always_comb begin
        logic [REM_W-1:0] trial;
        logic             ge;
        n_div = i_div;
        for (int k = 0; k < N_LANES; k++) begin
            trial = {i_div.lane[k].rem, i_div.lane[k].lo[Q_W-1]};
            ge    = (trial >= {1'b0, i_div.d});
            trial = ge ? (trial - {1'b0, i_div.d}) : trial;
            n_div.lane[k].rem = trial[DIV_W-1:0];
            n_div.lane[k].lo  = {i_div.lane[k].lo[Q_W-2:0], 1'b0};
            n_div.lane[k].q   = {i_div.lane[k].q[Q_W-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_div <= n_div;
        end
    end

    assign o_valid = r_valid;
    assign o_div   = r_div;

endmodule

`default_nettype wire

/* design/qrm_post.sv */
// ----------------------------------------------------------------------------
// qrm_post
// Sign, diagonal offset, zero-norm identity and clamp to plus or minus one.
// ----------------------------------------------------------------------------
`default_nettype none

module qrm_post
    import qrm_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_en,
    input  wire logic i_valid,
    input  wire t_div i_div,
    output logic      o_valid,
    output t_mat      o_mat
);

    logic r_valid;
    t_mat r_mat, n_mat;

    always_comb begin
        logic signed [VAL_W-1:0] val;
        for (int k = 0; k < N_LANES; k++) begin
            val = $signed(VAL_W'(i_div.lane[k].q));
            if (i_div.lane[k].neg) begin
                val = -val;
            end
            if (DIAG_MASK[k]) begin
                val = ONE - val;
            end
            if (i_div.zero) begin
                val = DIAG_MASK[k] ? ONE : '0;
            end
            if (val > ONE) begin
                val = ONE;
            end else if (val < -ONE) begin
                val = -ONE;
            end
            n_mat[k] = val[OUT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mat <= n_mat;
        end
    end

    assign o_valid = r_valid;
    assign o_mat   = r_mat;

endmodule

`default_nettype wire

/* design/quaternion_to_rotation_matrix.sv */
// ----------------------------------------------------------------------------
// quaternion_to_rotation_matrix
// Quaternion (Q2.14) to normalized 3x3 rotation matrix (Q2.14), fully piped.
// ----------------------------------------------------------------------------
// Takes one quaternion per cycle while o_stall is low and returns one matrix
// per quaternion, in order, through three front-end stages (products, norm
// and numerators, divider operands), a sixteen-stage restoring divider that
// settles one quotient bit per stage for all nine elements side by side, one
// finishing stage, and the output register. Any nonzero length is accepted;
// each element is rounded half away from zero and lies in [-1, +1]. A zero
// quaternion gives the identity. A two-entry output buffer keeps o_stall
// registered; o_stall rises in the cycle after a stalled output beat meets
// a second finished matrix.
// ----------------------------------------------------------------------------
`default_nettype none

module quaternion_to_rotation_matrix
    import qrm_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_valid,
    output logic                        o_stall,
    input  wire logic signed [IN_W-1:0] i_quat_w,
    input  wire logic signed [IN_W-1:0] i_quat_x,
    input  wire logic signed [IN_W-1:0] i_quat_y,
    input  wire logic signed [IN_W-1:0] i_quat_z,
    output logic                        o_valid,
    input  wire logic                   i_stall,
    output logic signed [OUT_W-1:0]     o_m00,
    output logic signed [OUT_W-1:0]     o_m01,
    output logic signed [OUT_W-1:0]     o_m02,
    output logic signed [OUT_W-1:0]     o_m10,
    output logic signed [OUT_W-1:0]     o_m11,
    output logic signed [OUT_W-1:0]     o_m12,
    output logic signed [OUT_W-1:0]     o_m20,
    output logic signed [OUT_W-1:0]     o_m21,
    output logic signed [OUT_W-1:0]     o_m22
);

    logic en;
    logic v_st [Q_W+1];
    t_div d_st [Q_W+1];
    logic v_post;
    t_mat m_post;

    logic r_out_valid, r_skid_valid;
    t_mat r_out, r_skid;
    logic take;

    assign en = ~r_skid_valid;

    qrm_prod u_prod (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (i_valid),
        .i_quat_w (i_quat_w),
        .i_quat_x (i_quat_x),
        .i_quat_y (i_quat_y),
        .i_quat_z (i_quat_z),
        .o_valid  (v_st[0]),
        .o_div    (d_st[0])
    );

    for (genvar s = 0; s < Q_W; s++) begin : g_div
        qrm_div_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (v_st[s]),
            .i_div   (d_st[s]),
            .o_valid (v_st[s+1]),
            .o_div   (d_st[s+1])
        );
    end

    qrm_post u_post (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (v_st[Q_W]),
        .i_div   (d_st[Q_W]),
        .o_valid (v_post),
        .o_mat   (m_post)
    );

    assign take = r_out_valid & ~i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || take) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= v_post;
            end
        end else if (!r_skid_valid && v_post) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || take) begin
            r_out <= r_skid_valid ? r_skid : m_post;
        end else if (!r_skid_valid) begin
            r_skid <= m_post;
        end
    end

    assign o_stall = r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_m00   = r_out[0];
    assign o_m01   = r_out[1];
    assign o_m02   = r_out[2];
    assign o_m10   = r_out[3];
    assign o_m11   = r_out[4];
    assign o_m12   = r_out[5];
    assign o_m20   = r_out[6];
    assign o_m21   = r_out[7];
    assign o_m22   = r_out[8];

    // buffer entry only ever backs up a held output beat
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("buffered beat without output beat");

    // buffer fills only when the output beat was stalled
    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_valid) |-> $past(r_out_valid && i_stall))
        else $error("buffer filled without output stall");

    // diagonal stays within plus or minus one
    a_diag_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (VAL_W'(o_m00) <= ONE) && (VAL_W'(o_m00) >= -ONE)
                 && (VAL_W'(o_m11) <= ONE) && (VAL_W'(o_m11) >= -ONE)
                 && (VAL_W'(o_m22) <= ONE) && (VAL_W'(o_m22) >= -ONE))
        else $error("diagonal element out of range");

endmodule

`default_nettype wire

/* bench/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the quaternion to rotation matrix block.
// ----------------------------------------------------------------------------
// A table of directed quaternions (zero, axis turns, full-scale and tiny
// values) is sent first. After it come about 1300 random quaternions of
// mixed shapes: full range, small, single axis, extreme values. Every matrix
// is predicted by exact integer arithmetic and checked element by element,
// in order. Both sides idle and stall in random bursts. Once, the output is
// held off long enough to fill the pipe and push back on the input.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
    import qrm_pkg::*;

    localparam int N_RANDOM    = 1300;
    localparam int N_QUIET     = 150;
    localparam int HOLD_CYCLES = 300;
    localparam logic signed [OUT_W-1:0] UNIT = OUT_W'(1) << FRAC_BITS;

    typedef logic [N_LANES-1:0][OUT_W-1:0] t_rot_mat;
    typedef logic signed [IN_W-1:0] t_qval;

    typedef struct {
        t_qval    w, x, y, z;
        bit       typed;
        t_rot_mat m;
    } t_quat_row;

    logic     i_clk    = 1'b0;
    logic     i_rst_n  = 1'b0;
    logic     i_valid  = 1'b0;
    logic     i_stall  = 1'b0;
    t_qval    i_quat_w = '0;
    t_qval    i_quat_x = '0;
    t_qval    i_quat_y = '0;
    t_qval    i_quat_z = '0;
    logic     o_stall;
    logic     o_valid;
    logic signed [OUT_W-1:0] o_m00, o_m01, o_m02, o_m10, o_m11, o_m12, o_m20, o_m21, o_m22;

    t_rot_mat  matrix_q[$];
    t_quat_row directed_rows[$];
    int        beats_sent   = 0;
    int        beats_seen   = 0;
    int        mismatches   = 0;
    bit        quiet        = 1'b0;
    int        idle_pct     = 15;
    int        stall_pct    = 15;

    quaternion_to_rotation_matrix i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_quat_w (i_quat_w),
        .i_quat_x (i_quat_x),
        .i_quat_y (i_quat_y),
        .i_quat_z (i_quat_z),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_m00    (o_m00),
        .o_m01    (o_m01),
        .o_m02    (o_m02),
        .o_m10    (o_m10),
        .o_m11    (o_m11),
        .o_m12    (o_m12),
        .o_m20    (o_m20),
        .o_m21    (o_m21),
        .o_m22    (o_m22)
    );

    always #5 i_clk = ~i_clk;

    // round(2 * num * 2^FRAC_BITS / nsq), half away from zero
    function automatic longint scaled_ratio(input longint num, input longint unsigned nsq);
        longint unsigned mag;
        longint unsigned q;
        mag = (num < 0) ? -num : num;
        q = ((mag << (FRAC_BITS + 2)) + nsq) / (nsq << 1);
        if (num < 0) return -longint'(q);
        return longint'(q);
    endfunction

    function automatic logic [OUT_W-1:0] clamp_elem(input longint v);
        longint one;
        one = longint'(1) << FRAC_BITS;
        if (v > one) v = one;
        if (v < -one) v = -one;
        return v[OUT_W-1:0];
    endfunction

    function automatic t_rot_mat diag_mat(input t_qval d0, input t_qval d1, input t_qval d2);
        t_rot_mat m;
        m = '0;
        m[0] = d0;
        m[4] = d1;
        m[8] = d2;
        return m;
    endfunction

    function automatic t_rot_mat rotation_of(input t_qval qw, input t_qval qx,
                                             input t_qval qy, input t_qval qz);
        longint w, x, y, z, one;
        longint x2, y2, z2, xy, xz, yz, wx, wy, wz;
        longint unsigned nsq;
        t_rot_mat m;
        w = qw; x = qx; y = qy; z = qz;
        one = longint'(1) << FRAC_BITS;
        x2 = x * x; y2 = y * y; z2 = z * z;
        xy = x * y; xz = x * z; yz = y * z;
        wx = w * x; wy = w * y; wz = w * z;
        nsq = w * w + x2 + y2 + z2;
        if (nsq == 0) return diag_mat(UNIT, UNIT, UNIT);
        m[0] = clamp_elem(one - scaled_ratio(y2 + z2, nsq));
        m[1] = clamp_elem(scaled_ratio(xy - wz, nsq));
        m[2] = clamp_elem(scaled_ratio(xz + wy, nsq));
        m[3] = clamp_elem(scaled_ratio(xy + wz, nsq));
        m[4] = clamp_elem(one - scaled_ratio(x2 + z2, nsq));
        m[5] = clamp_elem(scaled_ratio(yz - wx, nsq));
        m[6] = clamp_elem(scaled_ratio(xz - wy, nsq));
        m[7] = clamp_elem(scaled_ratio(yz + wx, nsq));
        m[8] = clamp_elem(one - scaled_ratio(x2 + y2, nsq));
        return m;
    endfunction

    task automatic add_row(input t_qval w, input t_qval x, input t_qval y, input t_qval z,
                           input bit typed, input t_rot_mat m);
        t_quat_row r;
        r.w = w; r.x = x; r.y = y; r.z = z;
        r.typed = typed;
        r.m = m;
        directed_rows.push_back(r);
    endtask

    task automatic send_quat(input t_qval w, input t_qval x, input t_qval y, input t_qval z,
                             input bit typed, input t_rot_mat m);
        int gap;
        gap = 0;
        if (!quiet && $urandom_range(0, 99) < idle_pct) gap = $urandom_range(1, 7);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_quat_w <= w;
        i_quat_x <= x;
        i_quat_y <= y;
        i_quat_z <= z;
        do @(posedge i_clk); while (o_stall);
        matrix_q.push_back(typed ? m : rotation_of(w, x, y, z));
        beats_sent++;
    endtask

    function automatic t_qval corner_val();
        case ($urandom_range(0, 5))
            0: return t_qval'(-32768);
            1: return t_qval'(32767);
            2: return t_qval'(0);
            3: return t_qval'(1);
            4: return t_qval'(-1);
            default: return t_qval'($urandom());
        endcase
    endfunction

    // stimulus
    initial begin
        t_rot_mat ident, none;
        t_qval    q[4];
        int       k;
        ident = diag_mat(UNIT, UNIT, UNIT);
        none  = '0;

        add_row(0, 0, 0, 0, 1'b1, ident);
        add_row(16384, 0, 0, 0, 1'b1, ident);
        add_row(-32768, 0, 0, 0, 1'b1, ident);
        add_row(1, 0, 0, 0, 1'b1, ident);
        add_row(0, 16384, 0, 0, 1'b1, diag_mat(UNIT, -UNIT, -UNIT));
        add_row(0, 0, -1, 0, 1'b1, diag_mat(-UNIT, UNIT, -UNIT));
        add_row(0, 0, 0, 32767, 1'b1, diag_mat(-UNIT, -UNIT, UNIT));
        add_row(0, 0, 0, 0, 1'b1, ident);
        add_row(32767, 32767, 32767, 32767, 1'b0, none);
        add_row(-32768, -32768, -32768, -32768, 1'b0, none);
        add_row(-32768, 32767, -32768, 32767, 1'b0, none);
        add_row(32767, -32768, 0, 0, 1'b0, none);
        add_row(11585, 11585, 0, 0, 1'b0, none);
        add_row(8192, 8192, 8192, 8192, 1'b0, none);
        add_row(16384, 16384, 16384, 16384, 1'b0, none);
        add_row(1, 1, 1, 1, 1'b0, none);
        add_row(0, 1, -1, 0, 1'b0, none);
        add_row(-1, -1, -1, -1, 1'b0, none);
        add_row(23170, 0, 23170, 0, 1'b0, none);
        add_row(100, -32768, 7, 32767, 1'b0, none);
        add_row(21845, -21846, 21845, -21846, 1'b0, none);
        add_row(-21846, 21845, -21846, 21845, 1'b0, none);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[r])
            send_quat(directed_rows[r].w, directed_rows[r].x, directed_rows[r].y,
                      directed_rows[r].z, directed_rows[r].typed, directed_rows[r].m);

        for (int n = 0; n < N_RANDOM; n++) begin
            if (n % 50 == 0) begin
                case ($urandom_range(0, 2))
                    0: idle_pct = 0;
                    1: idle_pct = 15;
                    default: idle_pct = 40;
                endcase
            end
            if (n >= N_RANDOM - N_QUIET) quiet = 1'b1;
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: begin
                    foreach (q[k2]) q[k2] = t_qval'($urandom());
                end
                5, 6: begin
                    foreach (q[k2]) q[k2] = t_qval'($urandom_range(0, 16)) - t_qval'(8);
                end
                7: begin
                    foreach (q[k2]) q[k2] = '0;
                    k = $urandom_range(0, 3);
                    q[k] = t_qval'($urandom());
                end
                8: begin
                    foreach (q[k2]) q[k2] = corner_val();
                end
                default: begin
                    foreach (q[k2]) q[k2] = t_qval'($urandom_range(0, 2)) - t_qval'(1);
                end
            endcase
            send_quat(q[0], q[1], q[2], q[3], 1'b0, none);
        end
        i_valid <= 1'b0;

        while (matrix_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        $display("%0d quaternions sent (zero, axis, extreme, tiny and random), %0d matrices",
                 beats_sent, beats_seen);
        $display("checked under random idling, stalls and one long output hold-off");
        if (mismatches == 0 && matrix_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // receiver: random stall bursts, plus one long hold-off to back up the pipe
    initial begin
        bit held;
        held = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if ($urandom_range(0, 63) == 0) begin
                case ($urandom_range(0, 2))
                    0: stall_pct = 0;
                    1: stall_pct = 10;
                    default: stall_pct = 30;
                endcase
            end
            if (!held && beats_sent >= 150) begin
                held = 1'b1;
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                i_stall <= 1'b0;
            end else if (!quiet && $urandom_range(0, 99) < stall_pct) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 7)) @(posedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    // output check
    always @(posedge i_clk) begin
        t_rot_mat got, want;
        if (i_rst_n && o_valid && !i_stall) begin
            got = {o_m22, o_m21, o_m20, o_m12, o_m11, o_m10, o_m02, o_m01, o_m00};
            beats_seen++;
            if (matrix_q.size() == 0) begin
                $display("%0t: matrix beat with nothing pending", $time);
                mismatches++;
            end else begin
                want = matrix_q.pop_front();
                for (int k = 0; k < N_LANES; k++) begin
                    if (got[k] !== want[k]) begin
                        $display("%0t: m%0d%0d expected %0d got %0d", $time, k / 3, k % 3,
                                 $signed(want[k]), $signed(got[k]));
                        mismatches++;
                    end
                end
            end
        end
    end

    initial begin
        #2_000_000;
        $display("timeout, %0d matrices still pending", matrix_q.size());
        $display("FAIL");
        $finish;
    end

endmodule

/* sim.f */
design/qrm_pkg.sv
design/qrm_prod.sv
design/qrm_div_step.sv
design/qrm_post.sv
design/quaternion_to_rotation_matrix.sv
bench/tb_top.sv
